### rtl/blr_pkg.sv
`timescale 1ns / 1ps

package blr_pkg;

	// Coordinate width of the square tile and the derived error width.
	localparam int CoordBits = 6;
	localparam int ColorBits = 24;
	// The error term stays within a few multiples of the larger span.
	localparam int ErrBits   = CoordBits + 3;

	// One line command.
	typedef struct packed {
		logic [CoordBits-1:0] start_x;
		logic [CoordBits-1:0] start_y;
		logic [CoordBits-1:0] end_x;
		logic [CoordBits-1:0] end_y;
		logic [ColorBits-1:0] pixel_color;
	} cmd_t;

	// One emitted pixel.
	typedef struct packed {
		logic [CoordBits-1:0] out_x;
		logic [CoordBits-1:0] out_y;
		logic [ColorBits-1:0] out_color;
		logic                 last_pixel;
	} pix_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic at_end;
		logic out_free;
	} sts_t;

endpackage

### rtl/bresenham_line_raster.sv
`timescale 1ns / 1ps

// Line rasterizer for a 64-by-64 tile.
// The cmd channel takes one line command (start point, end point, color).
// The pix channel gives every pixel of the line from start to end in
// Bresenham walk order; the end point comes last with last_pixel set.
// A line whose start equals its end gives a single pixel.
// Both channels use valid and ready; a transfer happens when both are high.
// The first pixel passes through the walk registers, loaded by the command,
// and then the output register. One pixel per cycle while pix_ready stays
// high; a line gives max(|dx|, |dy|) + 1 pixels, and the one-step error
// walk in the datapath sets this rate.
// A new command is taken once the end pixel sits in the output register,
// even while that pixel still waits to be taken.
// When the receiver stalls, the output register holds its pixel and the
// walk pauses until the pixel is taken.
// Reset clears the controller to idle and empties the output register.

module bresenham_line_raster (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  blr_pkg::cmd_t cmd,
	output logic          pix_valid,
	input  logic          pix_ready,
	output blr_pkg::pix_t pix
);

	blr_pkg::ctl_t ctl;
	blr_pkg::sts_t sts;

	// Controller state machine.
	blr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Walk registers and output register.
	blr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

endmodule

### rtl/blr_ctrl.sv
`timescale 1ns / 1ps

module blr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  blr_pkg::sts_t   sts,
	output blr_pkg::ctl_t   ctl
);

	blr_pkg::state_t state_q;
	blr_pkg::state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state: a command starts a walk, the end pixel closes it.
	always_comb begin
		state_next = state_q;
		case (state_q)
			blr_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_next = blr_pkg::ST_WALK;
				end
			end
			blr_pkg::ST_WALK: begin
				if (sts.out_free && sts.at_end) begin
					state_next = blr_pkg::ST_IDLE;
				end
			end
			default: state_next = blr_pkg::ST_IDLE;
		endcase
	end

	// Outputs: load on a command transfer, step in the walk state whenever the output slot frees up.
	always_comb begin
		cmd_ready = 1'b0;
		ctl.load  = 1'b0;
		ctl.step  = 1'b0;
		case (state_q)
			blr_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				ctl.load  = cmd_valid;
			end
			blr_pkg::ST_WALK: begin
				ctl.step = sts.out_free;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

endmodule

### rtl/blr_datapath.sv
`timescale 1ns / 1ps

module blr_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  blr_pkg::cmd_t   cmd,
	input  blr_pkg::ctl_t   ctl,
	output blr_pkg::sts_t   sts,
	output logic            pix_valid,
	input  logic            pix_ready,
	output blr_pkg::pix_t   pix
);

	localparam int CB = blr_pkg::CoordBits;
	localparam int EB = blr_pkg::ErrBits;

	logic [CB-1:0]                 cur_x_q, cur_y_q;
	logic [CB-1:0]                 goal_x_q, goal_y_q;
	logic [CB-1:0]                 span_x_q, span_y_q;
	logic                          dir_x_neg_q, dir_y_neg_q;
	logic signed [EB-1:0]          err_q;
	logic [blr_pkg::ColorBits-1:0] color_q;
	blr_pkg::pix_t                 pix_q;
	logic                          pix_valid_q;

	logic [CB-1:0]        span_x_new, span_y_new;
	logic signed [EB:0]   twice;
	logic signed [EB:0]   span_x_ext, span_y_ext;
	logic                 step_x, step_y;
	logic signed [EB-1:0] err_next;
	logic                 at_end;

	// Spans of a new command.
	always_comb begin
		span_x_new = (cmd.start_x > cmd.end_x) ? (cmd.start_x - cmd.end_x)
		                                       : (cmd.end_x - cmd.start_x);
		span_y_new = (cmd.start_y > cmd.end_y) ? (cmd.start_y - cmd.end_y)
		                                       : (cmd.end_y - cmd.start_y);
	end

	// Error walk decision for the current pixel.
	always_comb begin
		at_end     = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
		twice      = {err_q, 1'b0};
		span_x_ext = $signed({{(EB + 1 - CB){1'b0}}, span_x_q});
		span_y_ext = $signed({{(EB + 1 - CB){1'b0}}, span_y_q});
		step_x     = twice > -span_y_ext;
		step_y     = twice < span_x_ext;
		err_next   = err_q;
		if (step_x) begin
			err_next = err_next - $signed({{(EB - CB){1'b0}}, span_y_q});
		end
		if (step_y) begin
			err_next = err_next + $signed({{(EB - CB){1'b0}}, span_x_q});
		end
	end

	// Walk registers: loaded by a command, advanced on every step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			goal_x_q    <= '0;
			goal_y_q    <= '0;
			span_x_q    <= '0;
			span_y_q    <= '0;
			dir_x_neg_q <= 1'b0;
			dir_y_neg_q <= 1'b0;
			color_q     <= '0;
			err_q       <= '0;
		end else if (ctl.load) begin
			cur_x_q     <= cmd.start_x;
			cur_y_q     <= cmd.start_y;
			goal_x_q    <= cmd.end_x;
			goal_y_q    <= cmd.end_y;
			span_x_q    <= span_x_new;
			span_y_q    <= span_y_new;
			dir_x_neg_q <= !(cmd.start_x < cmd.end_x);
			dir_y_neg_q <= !(cmd.start_y < cmd.end_y);
			color_q     <= cmd.pixel_color;
			err_q       <= $signed({{(EB - CB){1'b0}}, span_x_new})
			             - $signed({{(EB - CB){1'b0}}, span_y_new});
		end else if (ctl.step) begin
			if (step_x) begin
				cur_x_q <= dir_x_neg_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
			end
			if (step_y) begin
				cur_y_q <= dir_y_neg_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
			end
			err_q <= err_next;
		end
	end

	// Output register payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (ctl.step) begin
			pix_q.out_x      <= cur_x_q;
			pix_q.out_y      <= cur_y_q;
			pix_q.out_color  <= color_q;
			pix_q.last_pixel <= at_end;
		end
	end

	// Output valid: set by a step, cleared by a transfer with nothing behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (ctl.step) begin
			pix_valid_q <= 1'b1;
		end else if (pix_ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	assign sts.at_end   = at_end;
	assign sts.out_free = !pix_valid_q || pix_ready;
	assign pix_valid    = pix_valid_q;
	assign pix          = pix_q;

endmodule

### tb/line_pixel_checker.sv
`timescale 1ns / 1ps

module line_pixel_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_ready,
	input  blr_pkg::cmd_t cmd,
	input  logic          pix_valid,
	input  logic          pix_ready,
	input  blr_pkg::pix_t pix,
	output int            pixels_pending,
	output int            lines_seen,
	output int            pixels_seen,
	output int            fail_count
);

	// Pixels still owed by the block, oldest first.
	blr_pkg::pix_t expected_pixels[$];

	initial begin
		pixels_pending = 0;
		lines_seen = 0;
		pixels_seen = 0;
		fail_count = 0;
	end

	// Walk one line the way the rasterizer should and queue every pixel it visits.
	function automatic void plan_line_pixels(input blr_pkg::cmd_t line);
		int span_x;
		int span_y;
		int err;
		int twice;
		logic [blr_pkg::CoordBits-1:0] pos_x;
		logic [blr_pkg::CoordBits-1:0] pos_y;
		logic x_back;
		logic y_back;
		blr_pkg::pix_t p;
		pos_x = line.start_x;
		pos_y = line.start_y;
		span_x = (line.start_x > line.end_x) ? line.start_x - line.end_x
			: line.end_x - line.start_x;
		span_y = (line.start_y > line.end_y) ? line.start_y - line.end_y
			: line.end_y - line.start_y;
		x_back = !(line.start_x < line.end_x);
		y_back = !(line.start_y < line.end_y);
		err = span_x - span_y;
		for (int n = 0; n < (1 << blr_pkg::CoordBits); n++) begin
			p.out_x = pos_x;
			p.out_y = pos_y;
			p.out_color = line.pixel_color;
			p.last_pixel = (pos_x == line.end_x) && (pos_y == line.end_y);
			expected_pixels = {expected_pixels, p};
			if (p.last_pixel)
				break;
			// Both decisions use the doubled error from before this step.
			twice = 2 * err;
			if (twice > -span_y) begin
				err -= span_y;
				pos_x = x_back ? pos_x - 1'b1 : pos_x + 1'b1;
			end
			if (twice < span_x) begin
				err += span_x;
				pos_y = y_back ? pos_y - 1'b1 : pos_y + 1'b1;
			end
		end
	endfunction

	// Compare each pixel transfer with the oldest expectation, then queue new lines.
	always @(posedge clk) begin
		blr_pkg::pix_t want;
		if (arst_n) begin
			if (pix_valid && pix_ready) begin
				pixels_seen++;
				if (expected_pixels.size() == 0) begin
					$error("unexpected pixel at (%0d,%0d) with no line pending",
						pix.out_x, pix.out_y);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (pix.out_x !== want.out_x) begin
						$error("out_x: expected %0d, got %0d", want.out_x, pix.out_x);
						fail_count++;
					end
					if (pix.out_y !== want.out_y) begin
						$error("out_y: expected %0d, got %0d", want.out_y, pix.out_y);
						fail_count++;
					end
					if (pix.out_color !== want.out_color) begin
						$error("out_color: expected %06h, got %06h",
							want.out_color, pix.out_color);
						fail_count++;
					end
					if (pix.last_pixel !== want.last_pixel) begin
						$error("last_pixel: expected %0b, got %0b",
							want.last_pixel, pix.last_pixel);
						fail_count++;
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				lines_seen++;
				plan_line_pixels(cmd);
			end
			pixels_pending = expected_pixels.size();
		end
	end

endmodule

### tb/bresenham_line_raster_test.sv
`timescale 1ns / 1ps

module bresenham_line_raster_test;

	localparam int RandomLines = 200;
	localparam int CalmLines   = 40;
	localparam int LongStall   = 300;
	localparam int CycleLimit  = 400000;

	logic          clk;
	logic          arst_n;
	logic          cmd_valid;
	logic          cmd_ready;
	blr_pkg::cmd_t cmd;
	logic          pix_valid;
	logic          pix_ready;
	blr_pkg::pix_t pix;

	int   pixels_pending;
	int   lines_seen;
	int   pixels_seen;
	int   fail_count;
	int   cycle_count = 0;
	int   directed_lines = 0;
	logic calm;
	logic want_long_stall;
	logic long_stall_done = 1'b0;

	bresenham_line_raster dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	line_pixel_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.pix_valid      (pix_valid),
		.pix_ready      (pix_ready),
		.pix            (pix),
		.pixels_pending (pixels_pending),
		.lines_seen     (lines_seen),
		.pixels_seen    (pixels_seen),
		.fail_count     (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CycleLimit);
		$display("== FAIL ==");
		$finish;
	end

	// Pixel receiver: random stall bursts, one long hold-off, none near the end.
	initial begin
		int hold;
		pix_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (calm) begin
				pix_ready <= 1'b1;
				hold = 1;
			end else if (want_long_stall && !long_stall_done) begin
				pix_ready <= 1'b0;
				hold = LongStall;
				long_stall_done = 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				pix_ready <= 1'b0;
				hold = $urandom_range(1, 5);
			end else begin
				pix_ready <= 1'b1;
				hold = $urandom_range(1, 12);
			end
			repeat (hold) @(posedge clk);
		end
	end

	function automatic blr_pkg::cmd_t make_line(input int sx, input int sy, input int ex,
			input int ey, input logic [blr_pkg::ColorBits-1:0] color);
		blr_pkg::cmd_t c;
		c.start_x = sx[blr_pkg::CoordBits-1:0];
		c.start_y = sy[blr_pkg::CoordBits-1:0];
		c.end_x = ex[blr_pkg::CoordBits-1:0];
		c.end_y = ey[blr_pkg::CoordBits-1:0];
		c.pixel_color = color;
		return c;
	endfunction

	// Mix of long random lines, short lines, axis and diagonal lines, and dots.
	function automatic blr_pkg::cmd_t random_line();
		int sx;
		int sy;
		int len;
		logic [31:0] rnd;
		logic [blr_pkg::ColorBits-1:0] color;
		sx = $urandom_range(0, 63);
		sy = $urandom_range(0, 63);
		rnd = $urandom();
		color = rnd[blr_pkg::ColorBits-1:0];
		len = $urandom_range(1, 63);
		case ($urandom_range(0, 5))
			0, 1: return make_line(sx, sy, $urandom_range(0, 63), $urandom_range(0, 63), color);
			2, 3: return make_line(sx, sy, sx + $urandom_range(0, 8) - 4,
				sy + $urandom_range(0, 8) - 4, color);
			4: begin
				case ($urandom_range(0, 3))
					0: return make_line(sx, sy, sx + len, sy, color);
					1: return make_line(sx, sy, sx, sy - len, color);
					2: return make_line(sx, sy, sx + len, sy + len, color);
					default: return make_line(sx, sy, sx - len, sy + len, color);
				endcase
			end
			default: return make_line(sx, sy, sx + $urandom_range(0, 1),
				sy - $urandom_range(0, 1), color);
		endcase
	endfunction

	// Hold the command until the block takes it.
	task automatic send_line(input blr_pkg::cmd_t c);
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// Optional idle burst between commands, with junk on the bus.
	task automatic sender_gap();
		logic [63:0] junk;
		if (!calm && $urandom_range(0, 3) == 0) begin
			junk = {$urandom(), $urandom()};
			cmd_valid <= 1'b0;
			cmd <= junk[$bits(blr_pkg::cmd_t)-1:0];
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_directed(input int sx, input int sy, input int ex, input int ey,
			input logic [blr_pkg::ColorBits-1:0] color);
		send_line(make_line(sx, sy, ex, ey, color));
		directed_lines++;
		sender_gap();
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		calm = 1'b0;
		want_long_stall = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Dots, full-length axis lines and corner-to-corner diagonals.
		send_directed(0, 0, 0, 0, 24'h000000);
		send_directed(63, 63, 63, 63, 24'hFFFFFF);
		send_directed(0, 0, 63, 0, 24'hAAAAAA);
		send_directed(63, 63, 0, 63, 24'h555555);
		send_directed(0, 0, 0, 63, 24'hFF0000);
		send_directed(63, 63, 63, 0, 24'h00FF00);
		send_directed(0, 0, 63, 63, 24'h0000FF);
		send_directed(63, 0, 0, 63, 24'h123456);
		send_directed(63, 63, 0, 0, 24'hFEDCBA);
		send_directed(0, 63, 63, 0, 24'h800001);
		// Shallow and steep lines with rising and falling slopes, some also reversed.
		send_directed(10, 20, 50, 30, 24'h0F0F0F);
		send_directed(50, 30, 10, 20, 24'hF0F0F0);
		send_directed(20, 10, 30, 50, 24'h3C3C3C);
		send_directed(30, 50, 20, 10, 24'hC3C3C3);
		send_directed(5, 40, 60, 33, 24'h7FFFFF);
		send_directed(40, 5, 33, 60, 24'h000001);
		send_directed(0, 62, 63, 1, 24'h00FFFF);
		// One-step lines.
		send_directed(0, 0, 1, 0, 24'hFFFF00);
		send_directed(0, 0, 1, 1, 24'hFF00FF);
		send_directed(32, 32, 31, 33, 24'h808080);

		// Random lines; the long output stall starts at the receiver's next decision.
		want_long_stall = 1'b1;
		for (int i = 0; i < RandomLines; i++) begin
			if (i == RandomLines - CalmLines)
				calm = 1'b1;
			send_line(random_line());
			sender_gap();
		end
		cmd_valid <= 1'b0;
		@(posedge clk);

		// Drain every outstanding pixel, then allow for any late extras.
		while (pixels_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Rasterized %0d lines (%0d directed) into %0d pixels.",
			lines_seen, directed_lines, pixels_seen);
		$display("Random stalls on both sides plus one %0d-cycle output hold-off.",
			LongStall);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
